// ===== hw/rtl/bade_pkg.sv =====
`default_nettype none
// ============================================================================
// bade_pkg
// Shared types, constants and a helper function for the bitmap and attribute
// display renderer.
// ============================================================================

package bade_pkg;

   // Video memory layout: bitmap first, attributes after it.
   localparam int unsigned BITMAP_DEPTH = 6144;
   localparam int unsigned ATTR_DEPTH   = 768;
   localparam int unsigned BITMAP_AW    = $clog2(BITMAP_DEPTH);
   localparam int unsigned ATTR_AW      = $clog2(ATTR_DEPTH);

   localparam logic [12:0] ATTR_BASE    = 13'h1800;
   localparam logic [12:0] VMEM_LIMIT   = 13'd6912;

   // Lines whose top two bits hold this value (192 and above) lie past the attribute area.
   localparam logic [1:0]  OFFSCREEN_TOP = 2'b11;

   localparam logic [5:0]  FLASH_PERIOD_RESET = 6'd25;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // Beat widths on the streaming ports.
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_DATA_W = 48;

   // Action codes carried in req_tuser.
   localparam logic [1:0] ACTION_WRITE  = 2'd0;
   localparam logic [1:0] ACTION_RENDER = 2'd1;
   localparam logic [1:0] ACTION_FRAME  = 2'd2;

   typedef enum logic [1:0] {
      CMD_WRITE_BITMAP,
      CMD_WRITE_ATTR,
      CMD_RENDER,
      CMD_FRAME
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [BITMAP_AW-1:0] bitmap_addr;
      logic [ATTR_AW-1:0]   attr_addr;
      logic [7:0]           wdata;
      logic [7:0]           line;
      logic [4:0]           column;
      logic                 offscreen;
   } cmd_type;

   // Expands one bitmap byte into eight palette indices, leftmost pixel in
   // the top nibble. Attribute: ink 2:0, paper 5:3, bright 6, flash 7.
   function automatic logic [31:0] render_pixels(input logic [7:0] bits,
                                                 input logic [7:0] attr,
                                                 input logic       flash_on);
      logic [3:0]  ink;
      logic [3:0]  paper;
      logic [3:0]  tmp;
      logic [31:0] word;
      ink   = {attr[6], attr[2:0]};
      paper = {attr[6], attr[5:3]};
      if (flash_on && attr[7]) begin
         tmp   = ink;
         ink   = paper;
         paper = tmp;
      end
      word = '0;
      for (int i = 0; i < 8; i++) begin
         word[31 - 4*i -: 4] = bits[7 - i] ? ink : paper;
      end
      return word;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bitmap_attribute_display_renderer_unit.sv =====
`default_nettype none
// ============================================================================
// bitmap_attribute_display_renderer_unit
// Bitmap and attribute display renderer with flash, top level.
// ============================================================================
//
// The unit holds a 6912-byte video memory (6144 bitmap bytes, then 768
// attribute bytes, one per 8x8 cell), kept in two RAMs that are not cleared
// at reset, so a byte must be written before it is rendered. Each request
// beat carries an action in req_tuser: a write stores one byte (addresses at
// or above 6912 are dropped), a render returns one response beat with eight
// 4-bit palette indices for one cell, and an end of frame advances the frame
// counter and toggles the flash phase every flash_period frames. Writes,
// frame beats and unused actions produce no response. The front half decodes
// each beat and computes the interleaved bitmap address and the attribute
// address; a short queue separates it from the back half, which performs the
// writes and runs the render in two stages: a registered read of both RAMs,
// then colour expansion into the output register. Lines 192 and above lie
// past the attribute area and render as index zero. A render passes the
// queue, the read stage and the output register, which drives its response
// beat. When nothing stalls, the unit sustains one beat per clock, set by
// the single read port of each RAM; a stalled response side holds at most
// one render in the read stage and one in the output register, and a render
// at the queue head then holds back every beat behind it. The flash_period
// register is written through the csr_ port, which is always ready, and
// must only be written while no beat is in flight.

module bitmap_attribute_display_renderer_unit #(
   parameter int unsigned QUEUE_DEPTH = bade_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel.
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // tdata from bit 0: write_address[12:0], write_data[20:13],
   // display_line[28:21], cell_column[33:29], zero fill[39:34].
   input  wire logic [bade_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: action[1:0].
   input  wire logic [bade_pkg::REQ_USER_W-1:0] req_tuser,
   // Response channel.
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata from bit 0: out_line[7:0], out_column[12:8],
   // pixel_colours[44:13], flash_phase[45], zero fill[47:46].
   output logic      [bade_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Configuration write channel: flash_period.
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [5:0]                      csr_wdata
);

   logic              q_full;
   logic              q_push;
   logic              q_pop;
   logic              q_valid;
   bade_pkg::cmd_type push_cmd;
   bade_pkg::cmd_type head_cmd;

   bade_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   bade_fifo #(
      .Depth (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_cmd (head_cmd)
   );

   bade_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/bade_ram.sv =====
`default_nettype none
// ============================================================================
// bade_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================

module bade_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bade_front.sv =====
`default_nettype none
// ============================================================================
// bade_front
// Accepts request beats, decodes the action and computes memory addresses.
// ============================================================================

module bade_front (
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [bade_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic [bade_pkg::REQ_USER_W-1:0] req_tuser,
   input  wire logic                            q_full,
   output logic                                 q_push,
   output bade_pkg::cmd_type                    q_cmd
);

   logic [12:0] waddr;
   logic [7:0]  wdata;
   logic [7:0]  line;
   logic [4:0]  column;
   logic [7:0]  row;
   logic        offscreen;
   logic        keep;

   assign waddr  = req_tdata[12:0];
   assign wdata  = req_tdata[20:13];
   assign line   = req_tdata[28:21];
   assign column = req_tdata[33:29];

   // Display rows interleave: line bits 0-2 and 3-5 trade places.
   assign row       = {line[7:6], line[2:0], line[5:3]};
   assign offscreen = (line[7:6] == bade_pkg::OFFSCREEN_TOP);

   assign req_tready = !q_full;

   always_comb begin
      q_cmd        = '0;
      q_cmd.wdata  = wdata;
      q_cmd.line   = line;
      q_cmd.column = column;
      q_cmd.offscreen = offscreen;
      keep         = 1'b0;
      unique case (req_tuser)
         bade_pkg::ACTION_WRITE: begin
            q_cmd.bitmap_addr = waddr;
            q_cmd.attr_addr   = waddr[bade_pkg::ATTR_AW-1:0];
            if (waddr < bade_pkg::ATTR_BASE) begin
               q_cmd.kind = bade_pkg::CMD_WRITE_BITMAP;
               keep       = 1'b1;
            end else if (waddr < bade_pkg::VMEM_LIMIT) begin
               q_cmd.kind = bade_pkg::CMD_WRITE_ATTR;
               keep       = 1'b1;
            end
         end
         bade_pkg::ACTION_RENDER: begin
            q_cmd.kind = bade_pkg::CMD_RENDER;
            keep       = 1'b1;
            // Past the attribute area the attribute reads as zero, which
            // paints the cell with index zero, so the addresses are parked.
            if (!offscreen) begin
               q_cmd.bitmap_addr = {row, column};
               q_cmd.attr_addr   = {line[7:3], column};
            end
         end
         bade_pkg::ACTION_FRAME: begin
            q_cmd.kind = bade_pkg::CMD_FRAME;
            keep       = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign q_push = req_tvalid && req_tready && keep;

endmodule

`default_nettype wire

// ===== hw/rtl/bade_fifo.sv =====
`default_nettype none
// ============================================================================
// bade_fifo
// Short command queue between the front and back halves.
// ============================================================================

module bade_fifo #(
   parameter int unsigned Depth = bade_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bade_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output logic                   valid,
   output bade_pkg::cmd_type      head_cmd
);

   localparam int unsigned PW = $clog2(Depth);
   localparam int unsigned CW = $clog2(Depth + 1);

   bade_pkg::cmd_type entry_ff [Depth];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff,  count_in;

   assign full     = (count_ff == CW'(Depth));
   assign valid    = (count_ff != '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bade_back.sv =====
`default_nettype none
// ============================================================================
// bade_back
// Executes queued commands: memory writes, frame counting, and the two-stage
// cell render (memory read, then colour expansion into the output register).
// ============================================================================

module bade_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_valid,
   input  wire bade_pkg::cmd_type               q_cmd,
   output logic                                 q_pop,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [5:0]                      csr_wdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [bade_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic is_render;
   logic advance;
   logic s2_free;
   logic bitmap_we;
   logic attr_we;
   logic read_en;
   logic [7:0] bitmap_rdata;
   logic [7:0] attr_rdata;
   logic [7:0] attr_eff;
   logic [6:0] frame_next;

   logic       s2_valid_ff, s2_valid_in;
   logic [7:0] s2_line_ff;
   logic [4:0] s2_column_ff;
   logic       s2_offscreen_ff;
   logic       s2_flash_ff;

   logic [5:0] flash_period_ff;
   logic [5:0] frame_count_ff, frame_count_in;
   logic       flash_on_ff,    flash_on_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bade_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   assign is_render = (q_cmd.kind == bade_pkg::CMD_RENDER);
   assign advance   = s2_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign s2_free   = !s2_valid_ff || advance;
   assign q_pop     = q_valid && (!is_render || s2_free);
   assign bitmap_we = q_pop && (q_cmd.kind == bade_pkg::CMD_WRITE_BITMAP);
   assign attr_we   = q_pop && (q_cmd.kind == bade_pkg::CMD_WRITE_ATTR);
   assign read_en   = q_pop && is_render;

   bade_ram #(
      .Width (8),
      .Depth (bade_pkg::BITMAP_DEPTH)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bitmap_we),
      .wr_addr (q_cmd.bitmap_addr),
      .wr_data (q_cmd.wdata),
      .rd_en   (read_en),
      .rd_addr (q_cmd.bitmap_addr),
      .rd_data (bitmap_rdata)
   );

   bade_ram #(
      .Width (8),
      .Depth (bade_pkg::ATTR_DEPTH)
   ) u_attr_ram (
      .clock   (clock),
      .wr_en   (attr_we),
      .wr_addr (q_cmd.attr_addr),
      .wr_data (q_cmd.wdata),
      .rd_en   (read_en),
      .rd_addr (q_cmd.attr_addr),
      .rd_data (attr_rdata)
   );

   // Frame counter and flash phase.
   assign frame_next = {1'b0, frame_count_ff} + 7'd1;

   always_comb begin
      frame_count_in = frame_count_ff;
      flash_on_in    = flash_on_ff;
      if (q_pop && (q_cmd.kind == bade_pkg::CMD_FRAME)) begin
         if (frame_next >= {1'b0, flash_period_ff}) begin
            frame_count_in = '0;
            flash_on_in    = !flash_on_ff;
         end else begin
            frame_count_in = frame_next[5:0];
         end
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         flash_period_ff <= bade_pkg::FLASH_PERIOD_RESET;
         frame_count_ff  <= '0;
         flash_on_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            flash_period_ff <= csr_wdata;
         end
         frame_count_ff <= frame_count_in;
         flash_on_ff    <= flash_on_in;
      end
   end

   // Render pipeline control.
   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (read_en) begin
         s2_valid_in = 1'b1;
      end else if (advance) begin
         s2_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign attr_eff = s2_offscreen_ff ? 8'h00 : attr_rdata;

   always_ff @(posedge clock) begin
      if (read_en) begin
         s2_line_ff      <= q_cmd.line;
         s2_column_ff    <= q_cmd.column;
         s2_offscreen_ff <= q_cmd.offscreen;
         s2_flash_ff     <= flash_on_ff;
      end
      if (advance) begin
         rsp_data_ff <= {2'b00, s2_flash_ff,
                         bade_pkg::render_pixels(bitmap_rdata, attr_eff, s2_flash_ff),
                         s2_column_ff, s2_line_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
